FILE: src/pcx_pkg.sv
package pcx_pkg;

   localparam int MAX_ROW_BYTES = 1024;
   localparam int MAX_WIDTH     = 8192;
   localparam int PALETTE_SIZE  = 256;
   localparam int STORE_PLANES  = 3;
   localparam int OFF_W         = $clog2(MAX_ROW_BYTES);
   localparam int PAL_W         = $clog2(PALETTE_SIZE);
   localparam int COL_W         = 13;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [7:0] RUN_MARK = 8'hC0;
   localparam logic [7:0] RUN_MASK = 8'h3F;

   localparam logic [1:0] CSR_PLANES = 2'd0;
   localparam logic [1:0] CSR_PBITS  = 2'd1;
   localparam logic [1:0] CSR_RBYTES = 2'd2;
   localparam logic [1:0] CSR_WIDTH  = 2'd3;

   localparam logic [1:0] KIND_PAL   = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_PIX   = 2'd2;

   typedef struct packed {
      logic [2:0]  planes;
      logic [3:0]  pbits;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [23:0]      data;
      logic [OFF_W-1:0] addr;
      logic [1:0]       plane;
      logic [3:0]       cnt;
      logic [COL_W-1:0] base;
      logic             row_end;
      logic             last;
   } cmd_type;

endpackage

FILE: src/pcx_ram.sv
module pcx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/pcx_front.sv
module pcx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_addr,
   input  logic [13:0]       csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  logic [39:0]       req_tdata,
   input  logic              q_full,
   output logic              q_push,
   output pcx_pkg::cmd_type  q_cmd,
   output pcx_pkg::cfg_type  cfg,
   output logic              expanding
);

   logic [2:0]  planes_ff, planes_in;
   logic [3:0]  pbits_ff, pbits_in;
   logic [10:0] rbytes_ff, rbytes_in;
   logic [13:0] width_ff, width_in;
   logic        pending_ff, pending_in;
   logic [5:0]  runlen_ff, runlen_in;
   logic        exp_ff, exp_in;
   logic [5:0]  rem_ff, rem_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  plane_ff, plane_in;
   logic [pcx_pkg::OFF_W-1:0] off_ff, off_in;

   logic [2:0]  planes_e;
   logic [10:0] rb_e;
   logic [13:0] w_e;
   logic [1:0]  sh;
   logic [3:0]  ppb;
   logic        lastplane, offend, vis, row_end, lastb, put, acc, is_data;
   logic [13:0] base, diff, lastoff_a, lastoff;
   logic [3:0]  cnt;
   logic [7:0]  code, cur_byte;

   assign code    = req_tdata[7:0];
   assign acc     = req_tvalid && req_tready;
   assign is_data = !req_tuser;

   always_comb begin
      planes_e = (planes_ff == 3'd0) ? 3'd1 : (planes_ff > 3'd4) ? 3'd4 : planes_ff;
      rb_e = (rbytes_ff == 11'd0) ? 11'd1 :
             (rbytes_ff > 11'(pcx_pkg::MAX_ROW_BYTES)) ? 11'(pcx_pkg::MAX_ROW_BYTES) :
             rbytes_ff;
      w_e = (width_ff > 14'(pcx_pkg::MAX_WIDTH)) ? 14'(pcx_pkg::MAX_WIDTH) : width_ff;
      sh  = (pbits_ff == 4'd8) ? 2'd0 : (pbits_ff == 4'd2) ? 2'd2 : 2'd3;
      ppb = 4'd1 << sh;
      lastplane = ({1'b0, plane_ff} == planes_e - 3'd1);
      offend    = ({1'b0, off_ff} == rb_e - 11'd1);
      base      = {4'b0, off_ff} << sh;
      vis       = lastplane && (base < w_e);
      diff      = w_e - base;
      cnt       = (diff > {10'b0, ppb}) ? ppb : diff[3:0];
      lastoff_a = (w_e - 14'd1) >> sh;
      lastoff   = (lastoff_a > {3'b0, rb_e - 11'd1}) ? {3'b0, rb_e - 11'd1} : lastoff_a;
      row_end   = ({4'b0, off_ff} == lastoff);
      put = exp_ff ? !q_full :
            (acc && is_data && !pending_ff && ((code & pcx_pkg::RUN_MARK) != pcx_pkg::RUN_MARK));
      cur_byte = exp_ff ? byte_ff : code;
      lastb = exp_ff ? (vis && (rem_ff == 6'd1 || offend || {4'b0, off_ff} >= lastoff)) : vis;
   end

   always_comb begin
      q_cmd         = '0;
      q_push        = 1'b0;
      q_cmd.addr    = off_ff;
      q_cmd.plane   = plane_ff;
      q_cmd.data    = {16'b0, cur_byte};
      if (acc && !is_data) begin
         q_push     = 1'b1;
         q_cmd.kind = pcx_pkg::KIND_PAL;
         q_cmd.addr = pcx_pkg::OFF_W'(req_tdata[15:8]);
         q_cmd.data = req_tdata[39:16];
      end else if (put && !lastplane) begin
         q_push     = 1'b1;
         q_cmd.kind = pcx_pkg::KIND_STORE;
      end else if (put && vis) begin
         q_push        = 1'b1;
         q_cmd.kind    = pcx_pkg::KIND_PIX;
         q_cmd.cnt     = cnt;
         q_cmd.base    = base[pcx_pkg::COL_W-1:0];
         q_cmd.row_end = row_end;
         q_cmd.last    = lastb;
      end
   end

   always_comb begin
      planes_in  = planes_ff;
      pbits_in   = pbits_ff;
      rbytes_in  = rbytes_ff;
      width_in   = width_ff;
      pending_in = pending_ff;
      runlen_in  = runlen_ff;
      exp_in     = exp_ff;
      rem_in     = rem_ff;
      byte_in    = byte_ff;
      plane_in   = plane_ff;
      off_in     = off_ff;
      if (put) begin
         if (offend) begin
            off_in   = '0;
            plane_in = lastplane ? 2'd0 : plane_ff + 2'd1;
         end else begin
            off_in = off_ff + 1'b1;
         end
      end
      if (exp_ff && put) begin
         rem_in = rem_ff - 6'd1;
         if (rem_ff == 6'd1 || (lastplane && offend)) begin
            exp_in = 1'b0;
         end
      end
      if (acc && is_data) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            byte_in    = code;
            rem_in     = runlen_ff;
            exp_in     = (runlen_ff != 6'd0);
         end else if ((code & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
            pending_in = 1'b1;
            runlen_in  = code[5:0] & pcx_pkg::RUN_MASK[5:0];
         end
      end
      if (csr_we) begin
         case (csr_addr)
            pcx_pkg::CSR_PLANES: planes_in = csr_wdata[2:0];
            pcx_pkg::CSR_PBITS:  pbits_in  = csr_wdata[3:0];
            pcx_pkg::CSR_RBYTES: rbytes_in = csr_wdata[10:0];
            default:             width_in  = csr_wdata;
         endcase
         pending_in = 1'b0;
         runlen_in  = 6'd0;
         exp_in     = 1'b0;
         plane_in   = 2'd0;
         off_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff  <= 3'd1;
         pbits_ff   <= 4'd8;
         rbytes_ff  <= 11'd1;
         width_ff   <= 14'd1;
         pending_ff <= 1'b0;
         runlen_ff  <= 6'd0;
         exp_ff     <= 1'b0;
         rem_ff     <= 6'd0;
         plane_ff   <= 2'd0;
         off_ff     <= '0;
      end else begin
         planes_ff  <= planes_in;
         pbits_ff   <= pbits_in;
         rbytes_ff  <= rbytes_in;
         width_ff   <= width_in;
         pending_ff <= pending_in;
         runlen_ff  <= runlen_in;
         exp_ff     <= exp_in;
         rem_ff     <= rem_in;
         plane_ff   <= plane_in;
         off_ff     <= off_in;
      end
      byte_ff <= byte_in;
   end

   assign req_tready = !exp_ff && !q_full;
   assign cfg.planes = planes_e;
   assign cfg.pbits  = pbits_ff;
   assign expanding  = exp_ff;

endmodule

FILE: src/pcx_queue.sv
module pcx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pcx_pkg::cmd_type  din,
   input  logic              pop,
   output pcx_pkg::cmd_type  head,
   output logic              full,
   output logic              empty
);

   localparam int AW = $clog2(pcx_pkg::QUEUE_DEPTH);

   pcx_pkg::cmd_type entry_ff [pcx_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wp_ff] <= din;
      end
   end

   assign head  = entry_ff[rp_ff];
   assign full  = (cnt_ff == (AW+1)'(pcx_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);

endmodule

FILE: src/pcx_back.sv
module pcx_back (
   input  logic              clock,
   input  logic              reset,
   input  pcx_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  pcx_pkg::cmd_type  q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   output logic [215:0]      rsp_tdata
);

   logic             a_valid_ff, a_valid_in, out_valid_ff, out_valid_in;
   logic             a_move, pop_pix;
   pcx_pkg::cmd_type a_cmd_ff;
   logic [7:0]       s_rd [pcx_pkg::STORE_PLANES];
   logic [23:0]      pal_rd;
   logic [23:0]      px [8];
   logic [215:0]     tdata_ff, tdata_in;
   logic             tuser_ff, tlast_ff;
   logic [7:0]       b, src, pix2;

   assign a_move  = a_valid_ff && (!out_valid_ff || rsp_tready);
   assign q_pop   = !q_empty && (q_head.kind != pcx_pkg::KIND_PIX || !a_valid_ff || a_move);
   assign pop_pix = q_pop && (q_head.kind == pcx_pkg::KIND_PIX);

   pcx_ram #(.WIDTH(24), .DEPTH(pcx_pkg::PALETTE_SIZE)) u_pal (
      .clock(clock),
      .we(q_pop && q_head.kind == pcx_pkg::KIND_PAL),
      .waddr(q_head.addr[pcx_pkg::PAL_W-1:0]),
      .wdata(q_head.data),
      .re(pop_pix),
      .raddr(q_head.data[pcx_pkg::PAL_W-1:0]),
      .rdata(pal_rd)
   );

   for (genvar i = 0; i < pcx_pkg::STORE_PLANES; i++) begin : g_store
      pcx_ram #(.WIDTH(8), .DEPTH(pcx_pkg::MAX_ROW_BYTES)) u_store (
         .clock(clock),
         .we(q_pop && q_head.kind == pcx_pkg::KIND_STORE && q_head.plane == 2'(i)),
         .waddr(q_head.addr),
         .wdata(q_head.data[7:0]),
         .re(pop_pix),
         .raddr(q_head.addr),
         .rdata(s_rd[i])
      );
   end

   always_comb begin
      b = a_cmd_ff.data[7:0];
      for (int k = 0; k < 8; k++) begin
         px[k] = '0;
         src   = '0;
         pix2  = b >> (6 - 2 * (k % 4));
         if (4'(k) < a_cmd_ff.cnt) begin
            if (cfg.pbits == 4'd8 && cfg.planes == 3'd3) begin
               px[k] = {s_rd[0], s_rd[1], b};
            end else if (cfg.pbits == 4'd8) begin
               px[k] = pal_rd;
            end else if (cfg.pbits == 4'd2) begin
               px[k] = {22'b0, pix2[1:0]};
            end else begin
               for (int p = 0; p < 4; p++) begin
                  if (3'(p) < cfg.planes) begin
                     src = b;
                     if (p < pcx_pkg::STORE_PLANES && 3'(p) < cfg.planes - 3'd1) begin
                        src = s_rd[p];
                     end
                     px[k][p] = src[7-k];
                  end
               end
            end
         end
      end
      tdata_in = '0;
      for (int k = 0; k < 8; k++) begin
         tdata_in[24*k +: 24] = px[k];
      end
      tdata_in[195:192] = a_cmd_ff.cnt;
      tdata_in[208:196] = a_cmd_ff.base;
   end

   always_comb begin
      a_valid_in   = pop_pix ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      out_valid_in = a_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop_pix) begin
         a_cmd_ff <= q_head;
      end
      if (a_move) begin
         tdata_ff <= tdata_in;
         tuser_ff <= a_cmd_ff.row_end;
         tlast_ff <= a_cmd_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;
   assign rsp_tlast  = tlast_ff;

endmodule

FILE: src/pcx_rle_scanline_decoder.sv
// PCX run-length scanline decoder.
// req channel: one beat per compressed byte (req_tuser 0) or palette write
// (req_tuser 1). Literal bytes and run headers are taken while req_tready is
// high; a run's data byte then holds req_tready low while the front run
// expander emits the repeated bytes, one byte a cycle when the queue has room.
// Bytes of the leading planes go to per-plane line stores; each visible byte
// of the last plane gives one rsp beat of up to eight pixels.
// rsp channel: pixel group with count and first column; rsp_tuser marks the
// group that ends the visible scanline, rsp_tlast the final group of a beat.
// A literal passes the queue write at the accepting edge, the store/palette
// read and the output register, which raises rsp_tvalid. Sustained rate with
// rsp_tready high: one literal byte per cycle, one decoded run byte per cycle.
// A four-entry queue parts the front from the back; when rsp_tready is low
// the output register and read stage hold, the queue fills, then req_tready
// drops. Reset clears the position, the run state and the registers to
// planes 1, 8 bits, 1 byte per row, width 1; stores and palette are
// undefined until written. The user must make csr writes only while idle;
// the block itself does not enforce this. A csr write also restarts the scanline.
module pcx_rle_scanline_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [13:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // func
   input  logic [39:0]  req_tdata,   // code_byte, palette_index, palette_rgb
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,   // row_end
   output logic         rsp_tlast,
   output logic [215:0] rsp_tdata    // pixel_0..pixel_7, pixel_count, first_column
);

   pcx_pkg::cmd_type q_cmd, q_head;
   pcx_pkg::cfg_type cfg;
   logic             q_push, q_pop, q_full, q_empty, expanding;

   pcx_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(q_cmd),
      .cfg(cfg),
      .expanding(expanding)
   );

   pcx_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .din(q_cmd),
      .pop(q_pop),
      .head(q_head),
      .full(q_full),
      .empty(q_empty)
   );

   pcx_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .rsp_tdata(rsp_tdata)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full && !q_pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("queue underflow");

   a_ready_idle_run: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !expanding)
      else $error("input taken during run expansion");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[195:192] != 4'd0 && rsp_tdata[195:192] <= 4'd8))
      else $error("pixel count out of range");

endmodule

FILE: tb/pcx_rle_scanline_decoder_test.sv
module pcx_rle_scanline_decoder_test;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_PAL  = 1'b1;
   localparam int   IDLE_PCT  = 32;
   localparam int   STALL_LIMIT = 2000;
   localparam int   SETTLE_CYCLES = 10;
   localparam int   HOLD_CYCLES = 300;
   localparam int   PAL_FILL = 16;

   typedef struct {
      logic [23:0] px[8];
      logic [3:0]  cnt;
      logic [12:0] col;
      logic        row_end;
      logic        last;
   } pixel_group_type;

   typedef struct {
      logic        func;
      logic [7:0]  code;
      logic [7:0]  idx;
      logic [23:0] rgb;
      bit          typed;
      logic [23:0] px0;
   } beat_row_type;

   typedef struct {
      int  planes;
      int  pbits;
      int  rbytes;
      int  width;
      int  items;
      bit  quiet;
   } phase_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [13:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic         req_tuser;
   logic [39:0]  req_tdata;   // code_byte, palette_index, palette_rgb
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         rsp_tuser;   // row_end
   logic         rsp_tlast;
   logic [215:0] rsp_tdata;   // pixel_0..pixel_7, pixel_count, first_column

   pcx_rle_scanline_decoder dut (.*);

   // decoder shadow state
   logic [7:0]   line_store[3072];
   logic [23:0]  palette[256];
   int           line_pos;
   bit           run_pending;
   int           run_len;
   logic [2:0]   cfg_planes;
   logic [3:0]   cfg_pbits;
   logic [10:0]  cfg_rbytes;
   logic [13:0]  cfg_width;

   pixel_group_type expected_groups[$];
   pixel_group_type beat_groups[$];

   int  errors = 0;
   int  bytes_sent = 0;
   int  groups_seen = 0;
   int  stall_count = 0;
   int  data_max = 255;
   bit  quiet = 0;
   bit  hold_go = 0;
   bit  hold_done = 0;
   int  hold_left = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic void place_byte(logic [7:0] b);
      int planes, rb, w, total, pos, plane, off, ppb, base, cnt, lastoff, p;
      logic [23:0] v;
      logic [7:0] pb;
      pixel_group_type g;
      planes = (cfg_planes == 0) ? 1 : (cfg_planes > 4) ? 4 : cfg_planes;
      rb = (cfg_rbytes == 0) ? 1 :
           (cfg_rbytes > pcx_pkg::MAX_ROW_BYTES) ? pcx_pkg::MAX_ROW_BYTES : cfg_rbytes;
      w = (cfg_width > pcx_pkg::MAX_WIDTH) ? pcx_pkg::MAX_WIDTH : cfg_width;
      total = planes * rb;
      pos = line_pos;
      plane = pos / rb;
      off = pos % rb;
      if (plane + 1 < planes) begin
         line_store[pos] = b;
      end else begin
         ppb = (cfg_pbits == 8) ? 1 : (cfg_pbits == 2) ? 4 : 8;
         base = off * ppb;
         if (base < w) begin
            cnt = (w - base > ppb) ? ppb : w - base;
            lastoff = (w - 1) / ppb;
            if (lastoff > rb - 1) lastoff = rb - 1;
            foreach (g.px[k]) g.px[k] = '0;
            for (int k = 0; k < cnt; k++) begin
               v = '0;
               if (cfg_pbits == 8 && planes == 3) begin
                  v = {line_store[off], line_store[rb + off], b};
               end else if (cfg_pbits == 8) begin
                  v = palette[b];
               end else if (cfg_pbits == 2) begin
                  v = (b >> (6 - 2 * k)) & 2'b11;
               end else begin
                  for (p = 0; p < planes; p++) begin
                     pb = (p + 1 < planes) ? line_store[p * rb + off] : b;
                     if (pb[7 - k]) v[p] = 1'b1;
                  end
               end
               g.px[k] = v;
            end
            g.cnt = 4'(cnt);
            g.col = 13'(base);
            g.row_end = (off == lastoff);
            g.last = 1'b0;
            beat_groups.push_back(g);
         end
      end
      pos++;
      line_pos = (pos >= total) ? 0 : pos;
   endfunction

   function automatic void decode_beat(logic func, logic [7:0] code, logic [7:0] idx,
                                       logic [23:0] rgb);
      beat_groups.delete();
      if (func == FUNC_PAL) begin
         palette[idx] = rgb;
         return;
      end
      if (run_pending) begin
         run_pending = 0;
         for (int i = 0; i < run_len; i++) begin
            place_byte(code);
            if (line_pos == 0) break;
         end
         run_len = 0;
      end else if ((code & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
         run_pending = 1;
         run_len = int'(code & pcx_pkg::RUN_MASK);
      end else begin
         place_byte(code);
      end
      if (beat_groups.size() > 0) beat_groups[beat_groups.size() - 1].last = 1'b1;
   endfunction

   task automatic send_beat(logic func, logic [7:0] code, logic [7:0] idx, logic [23:0] rgb,
                            bit typed = 0, logic [23:0] px0 = '0);
      pixel_group_type g;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {rgb, idx, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_beat(func, code, idx, rgb);
      if (typed) begin
         foreach (g.px[k]) g.px[k] = '0;
         g.px[0] = px0;
         g.cnt = 4'd1;
         g.col = '0;
         g.row_end = 1'b1;
         g.last = 1'b1;
         beat_groups.delete();
         beat_groups.push_back(g);
      end
      foreach (beat_groups[i]) expected_groups.push_back(beat_groups[i]);
      if (func == FUNC_BYTE) bytes_sent++;
   endtask

   // hold until every result is out and no run is still expanding
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_groups.size() > 0 || !req_tready) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] addr, logic [13:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         pcx_pkg::CSR_PLANES: cfg_planes = value[2:0];
         pcx_pkg::CSR_PBITS:  cfg_pbits  = value[3:0];
         pcx_pkg::CSR_RBYTES: cfg_rbytes = value[10:0];
         default:             cfg_width  = value[13:0];
      endcase
      line_pos = 0;
      run_pending = 0;
      run_len = 0;
   endtask

   task automatic send_random();
      int r;
      int lit_max;
      r = $urandom_range(99);
      lit_max = (data_max > 191) ? 191 : data_max;
      if (r < 15) begin
         send_beat(FUNC_PAL, 8'h00, 8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
      end else if (r < 40) begin
         send_beat(FUNC_BYTE, {2'b11, 6'($urandom_range(63))}, 8'h00, 24'h0);
         send_beat(FUNC_BYTE, 8'($urandom_range(data_max)), 8'h00, 24'h0);
      end else begin
         send_beat(FUNC_BYTE, 8'($urandom_range(lit_max)), 8'h00, 24'h0);
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // result checker
   always @(posedge clock) begin
      pixel_group_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         groups_seen++;
         if (expected_groups.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: expected none, actual tdata %h", $time, rsp_tdata);
         end else begin
            e = expected_groups.pop_front();
            for (int k = 0; k < 8; k++) begin
               if (rsp_tdata[24 * k +: 24] !== e.px[k]) begin
                  errors++;
                  $display("%0t pixel_%0d: expected %h, actual %h", $time, k, e.px[k],
                           rsp_tdata[24 * k +: 24]);
               end
            end
            if (rsp_tdata[195:192] !== e.cnt) begin
               errors++;
               $display("%0t pixel_count: expected %0d, actual %0d", $time, e.cnt,
                        rsp_tdata[195:192]);
            end
            if (rsp_tdata[208:196] !== e.col) begin
               errors++;
               $display("%0t first_column: expected %0d, actual %0d", $time, e.col,
                        rsp_tdata[208:196]);
            end
            if (rsp_tuser !== e.row_end) begin
               errors++;
               $display("%0t row_end: expected %b, actual %b", $time, e.row_end, rsp_tuser);
            end
            if (rsp_tlast !== e.last) begin
               errors++;
               $display("%0t last: expected %b, actual %b", $time, e.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("pcx_rle_scanline_decoder verification failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   beat_row_type directed[] = '{
      '{FUNC_PAL,  8'h00, 8'hBF, 24'h0A0B0C, 0, 24'h0},
      '{FUNC_PAL,  8'h00, 8'hC7, 24'h70C070, 0, 24'h0},
      '{FUNC_PAL,  8'h00, 8'h05, 24'hABCDEF, 0, 24'h0},
      '{FUNC_PAL,  8'h00, 8'hFF, 24'hFFFFFF, 0, 24'h0},
      '{FUNC_PAL,  8'h00, 8'h00, 24'h000000, 0, 24'h0},
      '{FUNC_BYTE, 8'h05, 8'h00, 24'h0,      1, 24'hABCDEF},
      '{FUNC_BYTE, 8'h00, 8'h00, 24'h0,      1, 24'h000000},
      '{FUNC_BYTE, 8'hC1, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_BYTE, 8'hFF, 8'h00, 24'h0,      1, 24'hFFFFFF},
      '{FUNC_BYTE, 8'hC0, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_BYTE, 8'h12, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_BYTE, 8'hFF, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_BYTE, 8'h05, 8'h00, 24'h0,      1, 24'hABCDEF},
      '{FUNC_BYTE, 8'hC2, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_PAL,  8'h00, 8'h3F, 24'h123456, 0, 24'h0},
      '{FUNC_BYTE, 8'h3F, 8'h00, 24'h0,      1, 24'h123456},
      '{FUNC_BYTE, 8'hBF, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_BYTE, 8'hC5, 8'h00, 24'h0,      0, 24'h0},
      '{FUNC_BYTE, 8'hC7, 8'h00, 24'h0,      0, 24'h0}
   };

   phase_type phases[] = '{
      '{3, 8,    4,    16,  8, 1},
      '{1, 2,    5,    18, 10, 0},
      '{4, 1,    3,    20,  7, 0},
      '{0, 0,    2,    16,  6, 0},
      '{1, 8,   64,    64,  8, 0},
      '{7, 15, 2047, 16383,  6, 0},
      '{2, 8,    0,     0,  4, 0}
   };

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      cfg_planes = 3'd1;
      cfg_pbits = 4'd8;
      cfg_rbytes = 11'd1;
      cfg_width = 14'd1;
      line_pos = 0;
      run_pending = 0;
      run_len = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the low palette entries; random palette-mode data stays within them
      for (int i = 0; i < PAL_FILL; i++)
         send_beat(FUNC_PAL, 8'h00, 8'(i), 24'($urandom_range(24'hFFFFFF)));
      foreach (directed[i])
         send_beat(directed[i].func, directed[i].code, directed[i].idx, directed[i].rgb,
                   directed[i].typed, directed[i].px0);

      foreach (phases[ph]) begin
         drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
         quiet = phases[ph].quiet;
         data_max = (phases[ph].pbits == 8 && phases[ph].planes != 3) ? PAL_FILL - 1 : 255;
         write_csr(pcx_pkg::CSR_PLANES, 14'(phases[ph].planes));
         write_csr(pcx_pkg::CSR_PBITS,  14'(phases[ph].pbits));
         write_csr(pcx_pkg::CSR_RBYTES, 14'(phases[ph].rbytes));
         write_csr(pcx_pkg::CSR_WIDTH,  14'(phases[ph].width));
         csr_we <= 1'b0;
         if (ph == 4) hold_go = 1;
         send_beat(FUNC_BYTE, 8'hFF, 8'h00, 24'h0);
         send_beat(FUNC_BYTE, 8'($urandom_range(data_max)), 8'h00, 24'h0);
         for (int i = 0; i < phases[ph].items; i++) begin
            if (ph == 1 && i == 8) drain();
            send_random();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d data bytes and %0d pixel groups over %0d register settings",
               bytes_sent, groups_seen, phases.size() + 1);
      $display("modes: 8-bit palette, 24-bit RGB, 2-bit, 1-bit planar, clamped registers");
      if (errors == 0) begin
         $display("pcx_rle_scanline_decoder verification clean");
      end else begin
         $display("pcx_rle_scanline_decoder verification failed");
      end
      $finish;
   end

endmodule
